>>> src/actuator_current_admission_unit_assert.svh
// Assertion macros for the actuator current admission unit.
`ifndef ACTUATOR_CURRENT_ADMISSION_UNIT_ASSERT_SVH
`define ACTUATOR_CURRENT_ADMISSION_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define ACA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ACA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ACA_ASSERT(label, clk, rst_n, prop, msg)
`define ACA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> src/aca_pkg.sv
// Shared types, constants and helpers of the actuator current admission unit.
package aca_pkg;
  localparam int unsigned Actuators   = 32;
  localparam int unsigned Instruments = 8;
  localparam int unsigned IdW   = 6;
  localparam int unsigned AIdxW = (Actuators > 1) ? $clog2(Actuators) : 1;
  localparam int unsigned InstW = 4;
  localparam int unsigned IIdxW = (Instruments > 1) ? $clog2(Instruments) : 1;
  localparam int unsigned CurW  = 20;
  localparam int unsigned MaW   = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;
  localparam logic [CurW-1:0] CurMax = '1;

  localparam logic [1:0] FuncQuery   = 2'd0;
  localparam logic [1:0] FuncActive  = 2'd1;
  localparam logic [1:0] FuncRelease = 2'd2;

  localparam logic [2:0] CauseNone    = 3'd0;
  localparam logic [2:0] CauseBadAct  = 3'd1;
  localparam logic [2:0] CauseVoices  = 3'd2;
  localparam logic [2:0] CauseSmart   = 3'd3;
  localparam logic [2:0] CauseInst    = 3'd4;
  localparam logic [2:0] CauseGlobal  = 3'd5;
  localparam logic [2:0] CauseServo   = 3'd6;
  localparam logic [2:0] CauseSolenoid = 3'd7;

  localparam logic [2:0] CfgGlobalLimit = 3'd0;
  localparam logic [2:0] CfgServoLimit  = 3'd1;
  localparam logic [2:0] CfgSolLimit    = 3'd2;
  localparam logic [2:0] CfgVoiceLimit  = 3'd3;
  localparam logic [2:0] CfgSmart       = 3'd4;
  localparam logic [2:0] CfgInstLimits  = 3'd5;
  localparam logic [2:0] CfgDegrade     = 3'd6;
  localparam logic [2:0] CfgLevels      = 3'd7;

  typedef struct packed {
    logic [1:0] func;
    logic [5:0] actuator_id;
    logic       actuator_enabled;
    logic [1:0] actuator_kind;
    logic       hit_and_hold;
    logic [1:0] bus_number;
    logic [3:0] instrument;
    logic [6:0] velocity;
  } item_t;

  typedef struct packed {
    logic        granted;
    logic [2:0]  reject_cause;
    logic [19:0] sum_cur;
    logic [19:0] servo_cur;
    logic [19:0] solenoid_cur;
    logic [7:0]  active_count;
    logic [6:0]  used_percent;
    logic        degraded;
    logic        over_budget;
    logic [31:0] rejections;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture item, read memory
    logic estimate;  // register current estimate
    logic apply;     // update counters
    logic div_start; // begin percent division
    logic div_step;  // one quotient bit
    logic finish;    // flags and result register
  } dp_cmd_t;

  typedef struct packed {
    logic refresh;   // item changes totals, needs percent refresh
    logic div_done;
  } dp_sts_t;

  function automatic logic [CurW-1:0] sat_add(input logic [CurW-1:0] a,
                                              input logic [MaW-1:0] b);
    logic [CurW:0] s;
    s = {1'b0, a} + {{(CurW+1-MaW){1'b0}}, b};
    return s[CurW] ? CurMax : s[CurW-1:0];
  endfunction

  function automatic logic [CurW-1:0] sat_sub(input logic [CurW-1:0] a,
                                              input logic [MaW-1:0] b);
    logic [CurW-1:0] bw;
    bw = {{(CurW-MaW){1'b0}}, b};
    return (a >= bw) ? a - bw : '0;
  endfunction
endpackage

>>> src/aca_if.sv
// Valid/ready channel interface carrying one payload.
interface aca_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/aca_ctrl.sv
// Sequencer for the admission unit: load, estimate, apply, divide, deliver.
module aca_ctrl import aca_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StEst  = 3'd1;
  localparam logic [2:0] StApp  = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StFin  = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [2:0] state_q, state_d;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = StEst;
        end
      end
      StEst: begin
        cmd_o.estimate = 1'b1;
        state_d = StApp;
      end
      StApp: begin
        cmd_o.apply = 1'b1;
        if (sts_i.refresh) begin
          cmd_o.div_start = 1'b1;
          state_d = StDiv;
        end else begin
          state_d = StFin;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) state_d = StFin;
      end
      StFin: begin
        cmd_o.finish = 1'b1;
        state_d = StOut;
      end
      StOut: begin
        if (out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

>>> src/aca_datapath.sv
// Admission datapath: configuration, allocation memory, counters, percent divider.
module aca_datapath import aca_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  item_t               item_i,
  input  dp_cmd_t             cmd_i,
  output dp_sts_t             sts_o,
  output result_t             res_o
);
  `include "actuator_current_admission_unit_assert.svh"

  // configuration registers
  logic [CurW-1:0] glim_q, slim_q, olim_q;
  logic [7:0]      vlim_q;
  logic            smart_q;
  logic [63:0]     ilim_q;
  logic [6:0]      deg_q;
  logic [47:0]     lvl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glim_q  <= 20'd4000;
      slim_q  <= 20'd2000;
      olim_q  <= 20'd3000;
      vlim_q  <= 8'd8;
      smart_q <= 1'b0;
      ilim_q  <= '0;
      deg_q   <= 7'd80;
      lvl_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgGlobalLimit: glim_q  <= cfg_data_i[CurW-1:0];
        CfgServoLimit:  slim_q  <= cfg_data_i[CurW-1:0];
        CfgSolLimit:    olim_q  <= cfg_data_i[CurW-1:0];
        CfgVoiceLimit:  vlim_q  <= cfg_data_i[7:0];
        CfgSmart:       smart_q <= cfg_data_i[0];
        CfgInstLimits:  ilim_q  <= cfg_data_i;
        CfgDegrade:     deg_q   <= cfg_data_i[6:0];
        CfgLevels:      lvl_q   <= cfg_data_i[47:0];
        default: ;
      endcase
    end
  end

  // captured item
  item_t it_q;
  logic  id_ok, inst_ok;
  logic [AIdxW-1:0] aidx;
  logic [IIdxW-1:0] iidx;
  assign id_ok   = ({26'd0, it_q.actuator_id} < 32'(Actuators));
  assign inst_ok = ({28'd0, it_q.instrument} < 32'(Instruments));
  assign aidx    = it_q.actuator_id[AIdxW-1:0];
  assign iidx    = it_q.instrument[IIdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) it_q <= item_i;
  end

  // current estimate; servo term divides by 127 with a shift-add that is exact
  // for products below 16k, solenoid term by reciprocal multiply on the product
  // registered at load
  localparam logic [23:0] Recip127 = 24'd8454661; // ceil(2^30 / 127)
  logic [15:0] lv_servo, lv_hold, lv_full, diff;
  logic [12:0] sp;      // v*50 <= 6350
  logic [22:0] dp_q;    // diff*v
  logic [45:0] dmul;
  logic [15:0] dq;
  logic [12:0] sq;
  logic [16:0] est_raw;
  logic [MaW-1:0] est_q;
  assign lv_servo = lvl_q[15:0];
  assign lv_hold  = lvl_q[31:16];
  assign lv_full  = lvl_q[47:32];
  assign diff     = (lv_full > lv_hold) ? lv_full - lv_hold : '0;
  assign sp       = 13'(it_q.velocity) * 13'd50;
  assign sq       = 13'((sp + (sp >> 7) + 13'd1) >> 7);
  assign dmul     = 46'(dp_q) * 46'(Recip127);
  assign dq       = dmul[45:30];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) dp_q <= 23'(diff) * 23'(item_i.velocity);
  end

  always_comb begin
    unique case (it_q.actuator_kind)
      2'd0:    est_raw = 17'(lv_servo) + 17'(sq);
      2'd1:    est_raw = it_q.hit_and_hold ? 17'(lv_full) : 17'(lv_hold) + 17'(dq);
      default: est_raw = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.estimate) est_q <= est_raw[16] ? 16'hFFFF : est_raw[15:0];
  end

  // allocation memory, tracked bits in flip-flops
  logic [MaW-1:0] alloc_mem [Actuators];
  logic [MaW-1:0] alloc_rd_q;
  logic [Actuators-1:0] tracked_q;
  logic [AIdxW-1:0] in_aidx;
  assign in_aidx = item_i.actuator_id[AIdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) alloc_rd_q <= alloc_mem[in_aidx];
    if (cmd_i.apply && id_ok && it_q.func == FuncActive) alloc_mem[aidx] <= est_q;
  end

  // state counters
  logic [CurW-1:0] tot_q, srv_q, sol_q;
  logic [7:0]      act_q;
  logic [7:0]      ivc_q [Instruments];
  logic [31:0]     rej_q;
  logic [6:0]      pct_q;
  logic            degf_q, overf_q;
  logic            gr_q, gr_d;
  logic [2:0]      cause_q, cause_d;

  // query checks
  logic [7:0] ilim;
  logic [CurW:0] need_tot, need_srv, need_sol;
  logic [2:0] qcause;
  assign ilim = (ilim_q[8*iidx +: 8] == 8'd0) ? vlim_q : ilim_q[8*iidx +: 8];
  assign need_tot = {1'b0, tot_q} + 21'(est_q);
  assign need_srv = {1'b0, srv_q} + 21'(est_q);
  assign need_sol = {1'b0, sol_q} + 21'(est_q);

  always_comb begin
    qcause = CauseNone;
    priority if (!id_ok || !it_q.actuator_enabled) qcause = CauseBadAct;
    else if (act_q >= vlim_q && !smart_q) qcause = CauseVoices;
    else if (act_q >= vlim_q && it_q.velocity < 7'd100) qcause = CauseSmart;
    else if (inst_ok && ivc_q[iidx] >= ilim) qcause = CauseInst;
    else if (need_tot > {1'b0, glim_q}) qcause = CauseGlobal;
    else if (it_q.bus_number == 2'd0 && need_srv > {1'b0, slim_q}) qcause = CauseServo;
    else if (it_q.bus_number == 2'd1 && need_sol > {1'b0, olim_q}) qcause = CauseSolenoid;
    else qcause = CauseNone;
  end

  logic do_act, do_rel;
  assign do_act = id_ok && it_q.func == FuncActive;
  assign do_rel = id_ok && it_q.func == FuncRelease && tracked_q[aidx];
  assign sts_o.refresh = do_act || do_rel;

  // grant and cause of the item
  always_comb begin
    gr_d    = 1'b0;
    cause_d = CauseNone;
    if (it_q.func == FuncQuery) begin
      cause_d = qcause;
      gr_d    = (qcause == CauseNone);
    end else if ((it_q.func == FuncActive || it_q.func == FuncRelease) && !id_ok) begin
      cause_d = CauseBadAct;
    end else if (do_act || do_rel) begin
      gr_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_q <= '0; srv_q <= '0; sol_q <= '0; act_q <= '0; rej_q <= '0;
      tracked_q <= '0;
      for (int i = 0; i < Instruments; i++) ivc_q[i] <= '0;
      gr_q <= 1'b0; cause_q <= CauseNone;
    end else if (cmd_i.apply) begin
      gr_q <= gr_d;
      cause_q <= cause_d;
      if (it_q.func == FuncQuery) begin
        if (qcause != CauseNone) rej_q <= rej_q + 32'd1;
      end else if (do_act) begin
        tracked_q[aidx] <= 1'b1;
        tot_q <= sat_add(tot_q, est_q);
        if (act_q != 8'hFF) act_q <= act_q + 8'd1;
        if (it_q.bus_number == 2'd0) srv_q <= sat_add(srv_q, est_q);
        else if (it_q.bus_number == 2'd1) sol_q <= sat_add(sol_q, est_q);
        if (inst_ok && ivc_q[iidx] != 8'hFF) ivc_q[iidx] <= ivc_q[iidx] + 8'd1;
      end else if (do_rel) begin
        tracked_q[aidx] <= 1'b0;
        tot_q <= sat_sub(tot_q, alloc_rd_q);
        if (act_q != 8'd0) act_q <= act_q - 8'd1;
        if (it_q.bus_number == 2'd0) srv_q <= sat_sub(srv_q, alloc_rd_q);
        else if (it_q.bus_number == 2'd1) sol_q <= sat_sub(sol_q, alloc_rd_q);
        if (inst_ok && ivc_q[iidx] != 8'd0) ivc_q[iidx] <= ivc_q[iidx] - 8'd1;
      end
    end
  end

  // total after this item, for the divider's dividend
  logic [CurW-1:0] tot_q_next;
  assign tot_q_next = do_act ? sat_add(tot_q, est_q) :
                      do_rel ? sat_sub(tot_q, alloc_rd_q) : tot_q;

  // restoring divider: total*100 / limit, 27-bit dividend, one bit a cycle
  localparam int unsigned DivW = 27;
  logic [DivW-1:0] dvd_q, quo_q;
  logic [CurW-1:0] rem_q;
  logic [4:0]      dcnt_q;
  logic [CurW+1:0] trial;
  logic [CurW:0]   rem_sh;
  assign rem_sh = {rem_q, dvd_q[DivW-1]};
  assign trial  = {1'b0, rem_sh} - {2'b0, glim_q};
  assign sts_o.div_done = (dcnt_q == 5'(DivW - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_start) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dvd_q <= 27'(tot_q_next) * 27'd100;
      rem_q <= '0;
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[DivW-2:0], 1'b0};
      if (!trial[CurW+1]) begin
        rem_q <= trial[CurW-1:0];
        quo_q <= {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[CurW-1:0];
        quo_q <= {quo_q[DivW-2:0], 1'b0};
      end
    end
  end

  // percent and flags, only on applied activation or release
  logic       refresh_q;
  logic [6:0] pct_new;
  assign pct_new = (glim_q == '0) ? 7'd0 : ((quo_q > 27'd100) ? 7'd100 : quo_q[6:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refresh_q <= 1'b0;
      pct_q <= '0; degf_q <= 1'b0; overf_q <= 1'b0;
    end else begin
      if (cmd_i.apply) refresh_q <= sts_o.refresh;
      if (cmd_i.finish && refresh_q) begin
        pct_q   <= pct_new;
        degf_q  <= (pct_new >= deg_q);
        overf_q <= (tot_q > glim_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_o.granted         <= gr_q;
      res_o.reject_cause    <= cause_q;
      res_o.sum_cur         <= tot_q;
      res_o.servo_cur       <= srv_q;
      res_o.solenoid_cur    <= sol_q;
      res_o.active_count    <= act_q;
      res_o.used_percent    <= refresh_q ? pct_new : pct_q;
      res_o.degraded        <= refresh_q ? (pct_new >= deg_q) : degf_q;
      res_o.over_budget     <= refresh_q ? (tot_q > glim_q) : overf_q;
      res_o.rejections      <= rej_q;
    end
  end

  `ACA_ASSERT(a_pct_range, clk_i, rst_ni, pct_q <= 7'd100, "percent out of range")
  `ACA_ASSERT(a_one_cmd, clk_i, rst_ni, $onehot0({cmd_i.load, cmd_i.estimate, cmd_i.apply, cmd_i.finish}), "overlapping commands")
  `ACA_ASSERT_NEXT(a_grant_cause, clk_i, rst_ni, cmd_i.apply, !(gr_q && cause_q != CauseNone), "grant with cause")
endmodule

>>> src/actuator_current_admission_unit.sv
// Top level of the actuator current admission unit.
// Each item passes the load, estimate, apply, finish and output states; an applied
// activation or release also runs the 27-step percent divider after apply.
// One item at a time: the next input transfer comes in the cycle after the output
// transfer, so an output stall holds the next item back.
// Reset: asynchronous, active low; counters and tracking clear, configuration
// returns to its defaults. No clearing pass.
module actuator_current_admission_unit import aca_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  aca_if.sink                 in_if,
  aca_if.source               out_if
);
  dp_cmd_t cmd;
  dp_sts_t sts;
  item_t   item;
  result_t res;

  assign item = in_if.data;
  assign out_if.data = res;

  aca_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  aca_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (item),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .res_o      (res)
  );
endmodule
